@@ src/pdc_pkg.sv @@
`timescale 1ns / 1ps

package pdc_pkg;

    localparam int LETTER_W = 5;
    localparam int COORD_W  = 3;
    localparam int SIDE     = 5;
    localparam int CELLS    = SIDE * SIDE;
    localparam int SQ_W     = 50;
    localparam int HIGH_W   = 25;
    localparam int CFG_IDX_W = 2;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_J   = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_I   = 5'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_SQ_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQ_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQ_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR     = 2'd3;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [CELLS-1:0][LETTER_W-1:0] t_square;

    // one digraph to substitute and how its results are delivered
    typedef struct packed {
        t_letter a;
        t_letter b;
        logic    two;       // two result letters
        logic    rep;       // second result repeats the substitute of a
        logic    last0;
        logic    last1;
    } t_job;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_pos;

    // first matching cell wins, no match gives row 0 column 0
    function automatic t_pos locate(t_square sq, t_letter letter);
        t_pos p;
        p.row = '0;
        p.col = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r * SIDE + c] == letter) begin
                    p.row = COORD_W'(r);
                    p.col = COORD_W'(c);
                end
            end
        end
        return p;
    endfunction

    // one step around the row or column, backward when decrypting
    function automatic t_coord wrap_step(t_coord x, logic dir);
        t_coord y;
        if (dir) begin
            y = (x == '0) ? COORD_W'(SIDE - 1) : x - 1'b1;
        end else begin
            y = (x == COORD_W'(SIDE - 1)) ? '0 : x + 1'b1;
        end
        return y;
    endfunction

    function automatic t_letter cell_code(t_square sq, t_coord row, t_coord col);
        logic [LETTER_W-1:0] idx;
        idx = LETTER_W'(row) * LETTER_W'(SIDE) + LETTER_W'(col);
        return sq[idx];
    endfunction

endpackage

@@ src/playfair_digraph_cipher_unit.sv @@
`timescale 1ns / 1ps
// path: a closed pair is queued, registered in the locate stage, then in the output stage
// throughput: one letter per cycle while the pair queue has room; a pair's two results
// leave the output stage in turn while the 4-entry pair queue keeps taking letters
// reset: synchronous active low, clears key square, direction, held letter, queue and
// both back stages; configuration writes are always ready

module playfair_digraph_cipher_unit
    import pdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [LETTER_W-1:0]  i_letter_in,
    input  logic                 i_last_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [LETTER_W-1:0]  o_letter_out,
    output logic                 o_last_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SQ_W-1:0]      i_cfg_data
);

    logic [SQ_W-1:0]   r_sq_low;
    logic [SQ_W-1:0]   r_sq_mid;
    logic [HIGH_W-1:0] r_sq_high;
    logic              r_direction;
    t_square           square;
    logic              push;
    t_job              push_job;
    logic              q_ready;
    logic              q_valid;
    t_job              q_job;
    logic              pop;

    assign o_cfg_ready = 1'b1;
    assign square      = {r_sq_high, r_sq_mid, r_sq_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_low    <= '0;
            r_sq_mid    <= '0;
            r_sq_high   <= '0;
            r_direction <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SQ_LOW:  r_sq_low    <= i_cfg_data;
                CFG_SQ_MID:  r_sq_mid    <= i_cfg_data;
                CFG_SQ_HIGH: r_sq_high   <= i_cfg_data[HIGH_W-1:0];
                CFG_DIR:     r_direction <= i_cfg_data[0];
                default:     r_direction <= r_direction;
            endcase
        end
    end

    pdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_letter_in (i_letter_in),
        .i_last_in   (i_last_in),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_job       (push_job)
    );

    pdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    pdc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_job      (q_job),
        .o_pop        (pop),
        .i_square     (square),
        .i_direction  (r_direction),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_letter_out (o_letter_out),
        .o_last_out   (o_last_out)
    );

endmodule

@@ src/pdc_front.sv @@
`timescale 1ns / 1ps

module pdc_front
    import pdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_letter i_letter_in,
    input  logic    i_last_in,
    input  logic    i_q_ready,
    output logic    o_push,
    output t_job    o_job
);

    logic    r_pend;
    logic    n_pend;
    t_letter r_pend_letter;
    t_letter n_pend_letter;
    t_letter letter;
    logic    accept;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign letter     = (i_letter_in == LETTER_J) ? LETTER_I : i_letter_in;

    always_comb begin
        n_pend        = r_pend;
        n_pend_letter = r_pend_letter;
        o_push        = 1'b0;
        o_job         = '0;
        if (accept) begin
            if (r_pend && letter != r_pend_letter) begin
                o_push      = 1'b1;
                o_job.a     = r_pend_letter;
                o_job.b     = letter;
                o_job.two   = 1'b1;
                o_job.last1 = i_last_in;
                n_pend      = 1'b0;
            end else if (r_pend) begin
                // doubled letter: pad the held one, a final repeat gives the same substitute
                o_push      = 1'b1;
                o_job.a     = r_pend_letter;
                o_job.b     = PAD_LETTER;
                o_job.two   = i_last_in;
                o_job.rep   = 1'b1;
                o_job.last1 = 1'b1;
                n_pend      = !i_last_in;
            end else if (i_last_in) begin
                o_push      = 1'b1;
                o_job.a     = letter;
                o_job.b     = PAD_LETTER;
                o_job.last0 = 1'b1;
            end else begin
                n_pend        = 1'b1;
                n_pend_letter = letter;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
        r_pend_letter <= n_pend_letter;
    end

endmodule

@@ src/pdc_queue.sv @@
`timescale 1ns / 1ps

module pdc_queue
    import pdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

@@ src/pdc_back.sv @@
`timescale 1ns / 1ps

module pdc_back
    import pdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_job    i_q_job,
    output logic    o_pop,
    input  t_square i_square,
    input  logic    i_direction,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_letter o_letter_out,
    output logic    o_last_out
);

    // locate stage
    logic    r_l_valid;
    t_pos    r_l_pa;
    t_pos    r_l_pb;
    logic    r_l_two;
    logic    r_l_rep;
    logic    r_l_last0;
    logic    r_l_last1;

    // output stage
    logic    r_o_valid;
    logic    r_o_idx;
    t_letter r_o_first;
    t_letter r_o_second;
    logic    r_o_two;
    logic    r_o_last0;
    logic    r_o_last1;

    logic    l_ready;
    logic    o_free;
    logic    o_load;
    t_pos    pa;
    t_pos    pb;
    t_pos    na;
    t_pos    nb;
    t_letter sa;
    t_letter sb;

    assign o_free  = !r_o_valid || (i_out_ready && (r_o_idx || !r_o_two));
    assign o_load  = r_l_valid && o_free;
    assign l_ready = !r_l_valid || o_free;
    assign o_pop   = i_q_valid && l_ready;

    assign pa = locate(i_square, i_q_job.a);
    assign pb = locate(i_square, i_q_job.b);

    always_comb begin
        na = r_l_pa;
        nb = r_l_pb;
        if (r_l_pa.row == r_l_pb.row) begin
            na.col = wrap_step(r_l_pa.col, i_direction);
            nb.col = wrap_step(r_l_pb.col, i_direction);
        end else if (r_l_pa.col == r_l_pb.col) begin
            na.row = wrap_step(r_l_pa.row, i_direction);
            nb.row = wrap_step(r_l_pb.row, i_direction);
        end else begin
            na.col = r_l_pb.col;
            nb.col = r_l_pa.col;
        end
        sa = cell_code(i_square, na.row, na.col);
        sb = cell_code(i_square, nb.row, nb.col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_idx   <= 1'b0;
        end else begin
            if (l_ready) begin
                r_l_valid <= i_q_valid;
            end
            if (o_free) begin
                r_o_valid <= r_l_valid;
            end
            if (o_load) begin
                r_o_idx <= 1'b0;
            end else if (r_o_valid && i_out_ready && !r_o_idx && r_o_two) begin
                r_o_idx <= 1'b1;
            end
        end
        if (o_pop) begin
            r_l_pa    <= pa;
            r_l_pb    <= pb;
            r_l_two   <= i_q_job.two;
            r_l_rep   <= i_q_job.rep;
            r_l_last0 <= i_q_job.last0;
            r_l_last1 <= i_q_job.last1;
        end
        if (o_load) begin
            r_o_first  <= sa;
            r_o_second <= r_l_rep ? sa : sb;
            r_o_two    <= r_l_two;
            r_o_last0  <= r_l_last0;
            r_o_last1  <= r_l_last1;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_letter_out = r_o_idx ? r_o_second : r_o_first;
    assign o_last_out   = r_o_idx ? r_o_last1 : r_o_last0;

`ifndef SYNTHESIS
    a_second_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_idx |-> r_o_two)
        else $error("second letter shown for a single-result pair");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_idx && r_o_two && i_out_ready |=> r_o_valid && r_o_idx)
        else $error("second letter of a pair lost");

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_last0 |-> !r_o_two)
        else $error("final mark on a first letter that has a follower");
`endif

endmodule
